// ----- src/plbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending lookup buffer table package
// Shared codes, reset values and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package plbt_pkg;

  // Default sizing
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_TAG_WIDTH   = 16;

  // Request commands
  typedef enum logic [1:0] {
    CMD_BUFFER       = 2'd0,
    CMD_SEARCH_BEGIN = 2'd1,
    CMD_SEARCH_END   = 2'd2,
    CMD_DISCOVERY    = 2'd3
  } plbt_cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED        = 3'd0,
    ST_DUPLICATE     = 3'd1,
    ST_FULL          = 3'd2,
    ST_CONFIRMED     = 3'd3,
    ST_RELEASED      = 3'd4,
    ST_SEARCH_FAILED = 3'd5,
    ST_ABSENT        = 3'd6
  } plbt_status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ENTRIES    = 2'd0;
  localparam logic [1:0] CFG_UNCONF_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE        = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  RST_MAX_ENTRIES    = 6'd30;
  localparam logic [15:0] RST_UNCONF_TIMEOUT = 16'd1;
  localparam logic [15:0] RST_MAX_AGE        = 16'd120;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;        // latch the request
    logic addr_clr;    // restart the table walk
    logic walk;        // step the table walk
    logic purge_mode;  // walk evicts stale entries
    logic act_store;   // write the new entry at the free slot
    logic act_confirm; // set confirmed on the hit entry
    logic act_free;    // drop the hit entry
  } plbt_ctrl_t;

  // Datapath -> controller status
  typedef struct packed {
    plbt_cmd_t cmd;       // latched command
    logic      walk_done; // walk finished, all compares settled
    logic      found;     // key present
    logic      full;      // entry count at capacity
    logic      free_ok;   // a free slot was seen on the last walk
  } plbt_stat_t;

endpackage

// ----- src/pending_lookup_buffer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending lookup buffer table
// Parks packet tags keyed by a 128-bit destination address while a lookup
// runs; handles buffer, search begin, search end and discovery requests.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its single result appears on out_* with out_valid high for exactly
// one cycle; the receiver cannot stall it. Every request walks the whole table
// through the one read port of the entry memory, one entry per cycle. A buffer
// request that finds no duplicate then takes a store step, and when it finds
// the table full a stale purge walk runs before that step. busy drops in the
// strobe cycle, so the next request can be taken there. Configuration writes
// take effect at once and belong in idle time.
// ----------------------------------------------------------------------------
module pending_lookup_buffer_table #(
  parameter int TABLE_DEPTH = plbt_pkg::DEF_TABLE_DEPTH,
  parameter int TAG_WIDTH   = plbt_pkg::DEF_TAG_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [15:0] in_message_tag,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_released_tag,
  output logic [5:0]  out_evicted_count
);

  plbt_pkg::plbt_ctrl_t ctrl;
  plbt_pkg::plbt_stat_t stat;

  // Sequencer
  plbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  // Table storage and walk
  plbt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_addr_high      (in_addr_high),
    .in_addr_low       (in_addr_low),
    .in_message_tag    (in_message_tag),
    .in_now_seconds    (in_now_seconds),
    .ctrl              (ctrl),
    .stat              (stat),
    .out_released_tag  (out_released_tag),
    .out_evicted_count (out_evicted_count)
  );

  // An accepted request always occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // The result strobe coincides with the end of the request
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside end of request");

  // Only discovery hands back a tag
  a_tag_only_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != plbt_pkg::ST_RELEASED) |-> out_released_tag == 16'd0)
    else $error("released tag on a non-release result");

  // Purges only happen for buffer requests
  a_evict_buffer_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_evicted_count != 6'd0)
      |-> (out_status == plbt_pkg::ST_STORED || out_status == plbt_pkg::ST_FULL))
    else $error("evictions reported on a non-buffer result");

endmodule

// ----- src/plbt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending lookup buffer table controller
// Sequences the key search walk, the optional stale purge walk and the final
// table update, and drives the result strobe and status.
// ----------------------------------------------------------------------------
module plbt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  plbt_pkg::plbt_stat_t    stat,
  output plbt_pkg::plbt_ctrl_t    ctrl,
  output logic                    busy,
  output logic                    out_valid,
  output logic [2:0]              out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_PURGE,
    S_STORE
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   valid_r, valid_nxt;
  plbt_pkg::plbt_status_t status_r, status_nxt;

  // Next state, commands and result
  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    ctrl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load     = 1'b1;
          ctrl.addr_clr = 1'b1;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        ctrl.walk = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
        if (stat.cmd == plbt_pkg::CMD_BUFFER) begin
          if (stat.found) begin
            status_nxt = plbt_pkg::ST_DUPLICATE;
          end else if (stat.full) begin
            // table full: purge stale entries first
            ctrl.addr_clr = 1'b1;
            valid_nxt     = 1'b0;
            state_nxt     = S_PURGE;
          end else begin
            valid_nxt = 1'b0;
            state_nxt = S_STORE;
          end
        end else if (!stat.found) begin
          status_nxt = plbt_pkg::ST_ABSENT;
        end else begin
          unique case (stat.cmd)
            plbt_pkg::CMD_SEARCH_BEGIN: begin
              ctrl.act_confirm = 1'b1;
              status_nxt       = plbt_pkg::ST_CONFIRMED;
            end
            plbt_pkg::CMD_SEARCH_END: begin
              ctrl.act_free = 1'b1;
              status_nxt    = plbt_pkg::ST_SEARCH_FAILED;
            end
            default: begin
              ctrl.act_free = 1'b1;
              status_nxt    = plbt_pkg::ST_RELEASED;
            end
          endcase
        end
      end
      S_PURGE: begin
        ctrl.walk       = 1'b1;
        ctrl.purge_mode = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
        if (stat.full || !stat.free_ok) begin
          status_nxt = plbt_pkg::ST_FULL;
        end else begin
          ctrl.act_store = 1'b1;
          status_nxt     = plbt_pkg::ST_STORED;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      status_r <= plbt_pkg::ST_STORED;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

// ----- src/plbt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending lookup buffer table datapath
// Configuration registers, the entry memory, valid bits, entry count and the
// one-entry-per-cycle walk used for key search and stale purge.
// ----------------------------------------------------------------------------
module plbt_datapath #(
  parameter int TABLE_DEPTH = plbt_pkg::DEF_TABLE_DEPTH,
  parameter int TAG_WIDTH   = plbt_pkg::DEF_TAG_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic [1:0]           in_command,
  input  logic [63:0]          in_addr_high,
  input  logic [63:0]          in_addr_low,
  input  logic [15:0]          in_message_tag,
  input  logic [31:0]          in_now_seconds,
  input  plbt_pkg::plbt_ctrl_t ctrl,
  output plbt_pkg::plbt_stat_t stat,
  output logic [15:0]          out_released_tag,
  output logic [5:0]           out_evicted_count
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CAPW = (CW > 6) ? CW : 6;
  // entry word: {confirmed, time, tag, key_low, key_high}
  localparam int TG_LO  = 128;
  localparam int TM_LO  = TG_LO + TAG_WIDTH;
  localparam int CF_BIT = TM_LO + 32;
  localparam int WW     = CF_BIT + 1;

  // Configuration registers
  logic [5:0]  max_ent_r;
  logic [15:0] uto_r;
  logic [15:0] mage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ent_r <= plbt_pkg::RST_MAX_ENTRIES;
      uto_r     <= plbt_pkg::RST_UNCONF_TIMEOUT;
      mage_r    <= plbt_pkg::RST_MAX_AGE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plbt_pkg::CFG_MAX_ENTRIES:    max_ent_r <= cfg_wdata[5:0];
        plbt_pkg::CFG_UNCONF_TIMEOUT: uto_r     <= cfg_wdata;
        plbt_pkg::CFG_MAX_AGE:        mage_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched request
  plbt_pkg::plbt_cmd_t  req_cmd_r;
  logic [63:0]          req_hi_r;
  logic [63:0]          req_lo_r;
  logic [TAG_WIDTH-1:0] req_tag_r;
  logic [31:0]          req_now_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd_r <= plbt_pkg::plbt_cmd_t'(in_command);
      req_hi_r  <= in_addr_high;
      req_lo_r  <= in_addr_low;
      req_tag_r <= TAG_WIDTH'(in_message_tag);
      req_now_r <= in_now_seconds;
    end
  end

  // Entry memory and walk state
  logic [WW-1:0]          mem [TABLE_DEPTH];
  logic [WW-1:0]          rd_data_r;
  logic [CW-1:0]          idx_r;
  logic                   p_r;
  logic [IW-1:0]          p_idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CW-1:0]          count_r;
  logic                   found_r;
  logic [IW-1:0]          hit_idx_r;
  logic [WW-1:0]          hit_word_r;
  logic                   free_ok_r;
  logic [IW-1:0]          free_idx_r;
  logic [CW-1:0]          evict_r;
  logic [TAG_WIDTH-1:0]   rel_tag_r;

  logic          issue;
  logic          p_valid;
  logic          key_hit;
  logic [31:0]   age;
  logic          stale;
  logic          evict;
  logic          keep;
  logic [CAPW-1:0] cap;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;

  // Walk issue and compare stage
  always_comb begin
    issue   = ctrl.walk && (idx_r != CW'(TABLE_DEPTH));
    p_valid = valid_r[p_idx_r];
    key_hit = p_valid && (rd_data_r[63:0] == req_hi_r) && (rd_data_r[127:64] == req_lo_r);
    age     = req_now_r - rd_data_r[TM_LO +: 32];
    stale   = p_valid && ((!rd_data_r[CF_BIT] && (age >= {16'd0, uto_r}))
                          || (age >= {16'd0, mage_r}));
    evict   = p_r && ctrl.purge_mode && stale;
    keep    = p_valid && !evict;
  end

  // Memory write select: new entry or confirm rewrite
  always_comb begin
    mem_we = ctrl.act_store || ctrl.act_confirm;
    mem_wa = ctrl.act_store ? free_idx_r : hit_idx_r;
    mem_wd = ctrl.act_store ? {1'b0, req_now_r, req_tag_r, req_lo_r, req_hi_r}
                            : {1'b1, hit_word_r[CF_BIT-1:0]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
    end
  end

  // Walk counter and compare pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      p_r   <= 1'b0;
    end else begin
      p_r <= issue;
      if (ctrl.addr_clr) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
    end
    p_idx_r <= idx_r[IW-1:0];
  end

  // Search hit, lowest free slot, purge and release bookkeeping
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      found_r   <= 1'b0;
      evict_r   <= '0;
      rel_tag_r <= '0;
    end else if (p_r && !ctrl.purge_mode && key_hit) begin
      found_r    <= 1'b1;
      hit_idx_r  <= p_idx_r;
      hit_word_r <= rd_data_r;
    end else if (evict) begin
      evict_r <= evict_r + CW'(1);
    end else if (ctrl.act_free && (req_cmd_r == plbt_pkg::CMD_DISCOVERY)) begin
      rel_tag_r <= hit_word_r[TG_LO +: TAG_WIDTH];
    end
    if (ctrl.addr_clr) begin
      free_ok_r <= 1'b0;
    end else if (p_r && !free_ok_r && !keep) begin
      free_ok_r  <= 1'b1;
      free_idx_r <= p_idx_r;
    end
  end

  // Valid bits and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (evict) begin
      valid_r[p_idx_r] <= 1'b0;
      count_r          <= count_r - CW'(1);
    end else if (ctrl.act_free) begin
      valid_r[hit_idx_r] <= 1'b0;
      count_r            <= count_r - CW'(1);
    end else if (ctrl.act_store) begin
      valid_r[free_idx_r] <= 1'b1;
      count_r             <= count_r + CW'(1);
    end
  end

  // Capacity is the smaller of max_entries and the table depth
  always_comb begin
    cap = (CAPW'(max_ent_r) < CAPW'(TABLE_DEPTH)) ? CAPW'(max_ent_r) : CAPW'(TABLE_DEPTH);
  end

  assign stat.cmd       = req_cmd_r;
  assign stat.walk_done = (idx_r == CW'(TABLE_DEPTH)) && !p_r;
  assign stat.found     = found_r;
  assign stat.full      = (CAPW'(count_r) >= cap);
  assign stat.free_ok   = free_ok_r;

  assign out_released_tag  = 16'(rel_tag_r);
  assign out_evicted_count = 6'(evict_r);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending lookup buffer table testbench
// Drives buffer, search begin, search end and discovery requests through the
// start/busy port and checks every result strobe against a cycle-free model of
// the table. The model tracks keys, tags, store times and confirmed flags. It
// covers duplicates, full drops, stale purges with wrapping and backward
// clocks, and several register settings that include the extremes.
// ----------------------------------------------------------------------------
module tb;
  import plbt_pkg::*;

  localparam int DEPTH  = DEF_TABLE_DEPTH;
  localparam int TAG_W  = DEF_TAG_WIDTH;
  localparam int POOL   = 40;
  localparam int NPHASE = 7;
  localparam int SETTLE = 2 * DEPTH + 12;

  typedef struct {
    plbt_status_t status;
    logic [15:0]  tag;
    logic [5:0]   evicted;
  } lookup_result_t;

  // Scoreboard: mirrors the table and queues the expected result per request
  class pending_table_scoreboard;
    bit               used [DEPTH];
    logic [63:0]      key_hi [DEPTH];
    logic [63:0]      key_lo [DEPTH];
    logic [TAG_W-1:0] parked_tag [DEPTH];
    logic [31:0]      stored_at [DEPTH];
    bit               confirmed [DEPTH];
    int               held;
    logic [5:0]       max_entries;
    logic [15:0]      unconf_timeout_s;
    logic [15:0]      max_age_s;
    lookup_result_t   expected_q[$];
    int               errors;
    int               checked;
    int               seen [7];
    int               purged;

    function new();
      max_entries      = RST_MAX_ENTRIES;
      unconf_timeout_s = RST_UNCONF_TIMEOUT;
      max_age_s        = RST_MAX_AGE;
      held    = 0;
      errors  = 0;
      checked = 0;
      purged  = 0;
      foreach (used[i]) used[i] = 1'b0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MAX_ENTRIES:    max_entries      = val[5:0];
        CFG_UNCONF_TIMEOUT: unconf_timeout_s = val;
        CFG_MAX_AGE:        max_age_s        = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Table update and result for one request
    function lookup_result_t predict_lookup(plbt_cmd_t cmd, logic [63:0] hi, logic [63:0] lo,
                                            logic [15:0] tag, logic [31:0] now_s);
      lookup_result_t r;
      int             hit;
      int             free_at;
      int             limit;
      logic [31:0]    age;
      r.status  = ST_ABSENT;
      r.tag     = '0;
      r.evicted = '0;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (hit < 0 && used[i] && key_hi[i] == hi && key_lo[i] == lo) hit = i;
      end
      limit = (int'(max_entries) < DEPTH) ? int'(max_entries) : DEPTH;
      if (cmd == CMD_BUFFER) begin
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else begin
          // full table: purge stale entries in one pass
          if (held >= limit) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (used[i]) begin
                age = now_s - stored_at[i];
                if ((!confirmed[i] && age >= {16'd0, unconf_timeout_s}) ||
                    age >= {16'd0, max_age_s}) begin
                  used[i] = 1'b0;
                  held--;
                  r.evicted++;
                end
              end
            end
          end
          free_at = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (free_at < 0 && !used[i]) free_at = i;
          end
          if (held >= limit || free_at < 0) begin
            r.status = ST_FULL;
          end else begin
            used[free_at]       = 1'b1;
            key_hi[free_at]     = hi;
            key_lo[free_at]     = lo;
            parked_tag[free_at] = tag[TAG_W-1:0];
            stored_at[free_at]  = now_s;
            confirmed[free_at]  = 1'b0;
            held++;
            r.status = ST_STORED;
          end
        end
      end else if (hit >= 0) begin
        case (cmd)
          CMD_SEARCH_BEGIN: begin
            confirmed[hit] = 1'b1;
            r.status = ST_CONFIRMED;
          end
          CMD_SEARCH_END: begin
            used[hit] = 1'b0;
            held--;
            r.status = ST_SEARCH_FAILED;
          end
          default: begin
            r.tag = 16'(parked_tag[hit]);
            used[hit] = 1'b0;
            held--;
            r.status = ST_RELEASED;
          end
        endcase
      end
      return r;
    endfunction

    function void note_request(plbt_cmd_t cmd, logic [63:0] hi, logic [63:0] lo,
                               logic [15:0] tag, logic [31:0] now_s);
      expected_q.push_back(predict_lookup(cmd, hi, lo, tag, now_s));
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [2:0] status, logic [15:0] tag, logic [5:0] evicted);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request outstanding, status %0d", status));
      end else begin
        want = expected_q.pop_front();
        checked++;
        seen[want.status]++;
        purged += want.evicted;
        if (status !== want.status)
          report($sformatf("status %0d, want %0d", status, want.status));
        if (tag !== want.tag)
          report($sformatf("released tag %h, want %h", tag, want.tag));
        if (evicted !== want.evicted)
          report($sformatf("evicted count %0d, want %0d", evicted, want.evicted));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [63:0] in_addr_high = '0;
  logic [63:0] in_addr_low = '0;
  logic [15:0] in_message_tag = '0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_released_tag;
  logic [5:0]  out_evicted_count;

  pending_table_scoreboard sb;
  logic [63:0] pool_hi [POOL];
  logic [63:0] pool_lo [POOL];
  logic [31:0] clock_s = '0;
  int          sent = 0;
  int          writes = 0;
  int          calm = 0;

  // per-phase settings: max_entries (upper bits set once), timeouts, request goal
  logic [15:0] set_max   [NPHASE] = '{16'd30, 16'hFFC8, 16'd63, 16'd32, 16'd0, 16'd1, 16'd12};
  logic [15:0] set_unc   [NPHASE] = '{16'd1, 16'd3, 16'd0, 16'hFFFF, 16'd5, 16'd2, 16'hFFFF};
  logic [15:0] set_age   [NPHASE] = '{16'd120, 16'd20, 16'd0, 16'hFFFF, 16'd10, 16'hFFFF,
                                      16'd40};
  int          set_goal  [NPHASE] = '{430, 720, 960, 1250, 1310, 1500, 1850};

  always #6 clk = ~clk;

  pending_lookup_buffer_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_addr_high      (in_addr_high),
    .in_addr_low       (in_addr_low),
    .in_message_tag    (in_message_tag),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_released_tag  (out_released_tag),
    .out_evicted_count (out_evicted_count)
  );

  // result monitor: strobe is good for exactly one cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_status, out_released_tag, out_evicted_count);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present a request and hold it until taken; returns on the accepting edge
  task automatic issue_request(plbt_cmd_t cmd, logic [63:0] hi, logic [63:0] lo,
                               logic [15:0] tag, logic [31:0] now_s);
    start          <= 1'b1;
    in_command     <= cmd;
    in_addr_high   <= hi;
    in_addr_low    <= lo;
    in_message_tag <= tag;
    in_now_seconds <= now_s;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, hi, lo, tag, now_s);
    sent++;
  endtask

  // drop start, let every result arrive, then let the block go quiet
  task automatic settle_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one write cycle, then one cycle with the enable low
  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
    writes++;
    @(posedge clk);
  endtask

  // one random request: clock drift, then optional gap before the next one
  task automatic send_item(plbt_cmd_t cmd, logic [63:0] hi, logic [63:0] lo, bit no_gaps);
    int r;
    r = $urandom_range(0, 999);
    if (r >= 550 && r < 940) clock_s += $urandom_range(1, 3);
    else if (r >= 940 && r < 970) clock_s += $urandom_range(4, 200);
    else if (r >= 970 && r < 985) clock_s += $urandom;
    else if (r >= 985) clock_s -= $urandom_range(1, 300);   // clock steps back
    issue_request(cmd, hi, lo, 16'($urandom), clock_s);
    if (!no_gaps) begin
      if (calm > 0) begin
        calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          calm = $urandom_range(10, 50);
        end else if (r < 5) begin
          // hold off until nothing is outstanding
          start <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end else if (r < 35) begin
          start <= 1'b0;
          if ($urandom_range(0, 1)) begin
            do @(posedge clk); while (busy);
          end
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
  endtask

  // mostly full lookup lifecycles on pooled keys, some noise
  task automatic run_phase(int goal, bit no_gaps);
    int j;
    int m;
    while (sent < goal) begin
      j = $urandom_range(0, POOL - 1);
      if ($urandom_range(0, 99) < 75) begin
        send_item(CMD_BUFFER, pool_hi[j], pool_lo[j], no_gaps);
        if ($urandom_range(0, 9) < 7)
          send_item(CMD_SEARCH_BEGIN, pool_hi[j], pool_lo[j], no_gaps);
        m = $urandom_range(0, 9);
        if (m < 6) send_item(CMD_DISCOVERY, pool_hi[j], pool_lo[j], no_gaps);
        else if (m < 9) send_item(CMD_SEARCH_END, pool_hi[j], pool_lo[j], no_gaps);
      end else if ($urandom_range(0, 1)) begin
        send_item(plbt_cmd_t'($urandom_range(0, 3)), pool_hi[j], pool_lo[j], no_gaps);
      end else begin
        send_item(plbt_cmd_t'($urandom_range(0, 3)), rand64(), rand64(), no_gaps);
      end
    end
  endtask

  initial begin
    sb = new();
    foreach (pool_hi[i]) begin
      pool_hi[i] = rand64();
      pool_lo[i] = rand64();
    end
    pool_hi[0] = '0;
    pool_lo[0] = '0;
    pool_hi[1] = '1;
    pool_lo[1] = '1;
    pool_hi[3] = pool_hi[2];   // keys that differ only in the low half
    pool_lo[5] = pool_lo[4];   // keys that differ only in the high half

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    issue_request(CMD_BUFFER, pool_hi[0], pool_lo[0], 16'h0000, 32'd0);
    issue_request(CMD_BUFFER, pool_hi[0], pool_lo[0], 16'h1234, 32'd0);
    issue_request(CMD_SEARCH_BEGIN, pool_hi[0], pool_lo[0], 16'h0000, 32'd0);
    issue_request(CMD_SEARCH_BEGIN, pool_hi[0], pool_lo[0], 16'h0000, 32'd0);
    issue_request(CMD_BUFFER, pool_hi[1], pool_lo[1], 16'hFFFF, 32'hFFFF_FFFF);
    issue_request(CMD_DISCOVERY, pool_hi[1], pool_lo[1], 16'h0000, 32'hFFFF_FFFF);
    issue_request(CMD_DISCOVERY, pool_hi[1], pool_lo[1], 16'h0000, 32'd0);
    issue_request(CMD_SEARCH_BEGIN, pool_hi[2], pool_lo[2], 16'h0000, 32'd0);
    issue_request(CMD_SEARCH_END, pool_hi[0], pool_lo[0], 16'h0000, 32'd1);
    issue_request(CMD_SEARCH_END, pool_hi[0], pool_lo[0], 16'h0000, 32'd1);
    issue_request(CMD_BUFFER, pool_hi[2], pool_lo[2], 16'hA5A5, 32'd10);
    issue_request(CMD_BUFFER, pool_hi[3], pool_lo[3], 16'h5A5A, 32'd10);
    issue_request(CMD_DISCOVERY, pool_hi[3], pool_lo[3], 16'h0000, 32'd10);

    // directed, two-entry table: full drop, partial purge, backward clock
    settle_idle();
    write_register(CFG_MAX_ENTRIES, 16'd2);
    issue_request(CMD_BUFFER, pool_hi[4], pool_lo[4], 16'h0101, 32'd100);
    issue_request(CMD_SEARCH_BEGIN, pool_hi[4], pool_lo[4], 16'h0000, 32'd100);
    issue_request(CMD_BUFFER, pool_hi[5], pool_lo[5], 16'h0202, 32'd100);
    issue_request(CMD_BUFFER, pool_hi[6], pool_lo[6], 16'h0303, 32'd100);
    issue_request(CMD_BUFFER, pool_hi[6], pool_lo[6], 16'h0303, 32'd101);
    issue_request(CMD_BUFFER, pool_hi[7], pool_lo[7], 16'h0404, 32'd50);
    issue_request(CMD_DISCOVERY, pool_hi[6], pool_lo[6], 16'h0000, 32'd50);
    issue_request(CMD_DISCOVERY, pool_hi[7], pool_lo[7], 16'h0000, 32'd50);

    // zero capacity refuses everything
    settle_idle();
    write_register(CFG_MAX_ENTRIES, 16'd0);
    issue_request(CMD_BUFFER, pool_hi[8], pool_lo[8], 16'h0505, 32'd60);

    // random phases, one register setting each; last one without gaps
    for (int p = 0; p < NPHASE; p++) begin
      settle_idle();
      write_register(CFG_MAX_ENTRIES, set_max[p]);
      write_register(CFG_UNCONF_TIMEOUT, set_unc[p]);
      write_register(CFG_MAX_AGE, set_age[p]);
      run_phase(set_goal[p], p == NPHASE - 1);
    end
    settle_idle();

    $display("tb: %0d requests, %0d results checked, %0d register writes, %0d stale purged",
             sent, sb.checked, writes, sb.purged);
    $display("tb: stored %0d dup %0d full %0d confirm %0d release %0d search-miss %0d absent %0d",
             sb.seen[ST_STORED], sb.seen[ST_DUPLICATE], sb.seen[ST_FULL],
             sb.seen[ST_CONFIRMED], sb.seen[ST_RELEASED], sb.seen[ST_SEARCH_FAILED],
             sb.seen[ST_ABSENT]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15000000;
    $display("FAIL");
    $finish;
  end

endmodule
